// ----- rtl/bcd_arith_pkg.sv -----
// package: types, opcodes and states for the bcd arithmetic unit
`timescale 1ns / 1ps
package bcd_arith_pkg;
    localparam int unsigned DIGITS_DEF = 16;
    localparam int unsigned WORD_W = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_CMP = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        operation;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              less_than;
        logic              equal;
        logic              divide_by_zero;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;
endpackage

// ----- rtl/bcd_fixed_width_arith_unit_top.sv -----
// top level: sequential bcd add, multiply, divide and compare unit
//
//  channel | signals                      | payload
//  in      | i_in_valid / o_in_stall      | bcd_arith_pkg::t_in_item
//  out     | o_out_valid / i_out_stall    | bcd_arith_pkg::t_out_item
//
// one shared digit adder/subtractor/multiplier (single bcd digit with carry)
// does all work: a compare pass over DIGITS digits first; add: one more pass;
// multiply: DIGITS rows of DIGITS digit steps; divide: DIGITS positions of up
// to ten trial subtractions over DIGITS+1 digits; then the result register
// loads; sync active-low reset clears only state and valid; stall holds result
`timescale 1ns / 1ps
module bcd_fixed_width_arith_unit_top #(
    parameter int unsigned DIGITS = bcd_arith_pkg::DIGITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  bcd_arith_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output bcd_arith_pkg::t_out_item o_out_item
);
    localparam int unsigned IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int unsigned RW = DIGITS + 1;   // remainder digits
    localparam int unsigned RIW = $clog2(RW);

    bcd_arith_pkg::t_state r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [3:0]        r_a [DIGITS];
    logic [3:0]        r_b [DIGITS];
    logic [3:0]        r_acc [DIGITS];    // sum / product / quotient
    logic [3:0]        r_rem [RW];        // divide remainder
    logic [3:0]        r_tmp [RW];        // trial difference
    logic [IW-1:0]     r_i, n_i;          // row / position
    logic [RIW-1:0]    r_j, n_j;          // digit within pass
    logic              r_cy, n_cy;
    logic [3:0]        r_mcy, n_mcy;      // multiply carry digit
    logic              r_lt, n_lt, r_eq, n_eq, r_dz, n_dz;
    logic              r_ovalid, n_ovalid;
    logic [3:0]        r_qd, n_qd;
    bcd_arith_pkg::t_out_item r_out;

    // digit unit selects
    logic [3:0] s_x, s_y, s_m;
    logic [3:0] s_add_d, s_sub_d;
    logic       s_add_c, s_sub_b;
    logic [4:0] s_sum;
    logic [4:0] s_dif;
    logic [7:0] s_prod;
    logic [8:0] s_mac;
    logic [16:0] s_mac_q;
    logic [3:0] s_mac_d, s_mac_c;
    logic       s_last_j;
    logic [IW-1:0] s_mul_k;
    logic          s_mul_in;
    logic [bcd_arith_pkg::WORD_W-1:0] s_res;

    function automatic logic [3:0] sat9(input logic [3:0] n);
        sat9 = (n > 4'd9) ? 4'd9 : n;
    endfunction

    // shared adder/subtractor and multiply-accumulate on one digit
    always_comb begin
        s_sum   = {1'b0, s_x} + {1'b0, s_y} + {4'd0, r_cy};
        s_add_c = (s_sum > 5'd9);
        s_add_d = s_add_c ? 4'(s_sum - 5'd10) : s_sum[3:0];
        s_dif   = {1'b0, s_x} - {1'b0, s_y} - {4'd0, r_cy};
        s_sub_b = s_dif[4];
        s_sub_d = s_sub_b ? 4'(s_dif + 5'd10) : s_dif[3:0];
        s_prod  = s_x * s_m;
        s_mac   = {1'b0, s_prod} + {5'd0, s_y} + {5'd0, r_mcy};
        // divide by ten as multiply by 205 and shift by 11, exact up to 99
        s_mac_q = 17'(s_mac) * 17'd205;
        s_mac_c = s_mac_q[14:11];
        s_mac_d = 4'(s_mac - 9'(s_mac_c) * 9'd10);
    end

    always_comb begin
        s_res = '0;
        for (int k = 0; k < DIGITS; k++) s_res[4*k +: 4] = r_acc[k];
    end

    always_comb begin
        s_x = '0; s_y = '0; s_m = '0;
        s_mul_k = IW'(r_i + IW'(r_j));
        s_mul_in = ({1'b0, r_i} + {1'b0, IW'(r_j)}) < (IW+1)'(DIGITS)
                   && 32'(r_j) < 32'(DIGITS);
        case (r_state)
            bcd_arith_pkg::ST_CMP: begin
                s_x = r_a[r_j[IW-1:0]];
                s_y = r_b[r_j[IW-1:0]];
            end
            bcd_arith_pkg::ST_ADD: begin
                s_x = r_a[r_j[IW-1:0]];
                s_y = r_b[r_j[IW-1:0]];
            end
            bcd_arith_pkg::ST_MUL: begin
                s_x = r_b[r_j[IW-1:0]];
                s_m = r_a[r_i];
                s_y = s_mul_in ? r_acc[s_mul_k] : 4'd0;
            end
            bcd_arith_pkg::ST_DIV: begin
                s_x = r_rem[r_j];
                s_y = (32'(r_j) < 32'(DIGITS)) ? r_b[r_j[IW-1:0]] : 4'd0;
            end
            default: ;
        endcase
    end

    assign s_last_j = (32'(r_j) == 32'(DIGITS - 1));

    always_comb begin
        n_state = r_state; n_op = r_op; n_i = r_i; n_j = r_j; n_cy = r_cy;
        n_mcy = r_mcy; n_lt = r_lt; n_eq = r_eq; n_dz = r_dz;
        n_ovalid = r_ovalid; n_qd = r_qd;
        if (r_ovalid && !i_out_stall) n_ovalid = 1'b0;
        case (r_state)
            bcd_arith_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bcd_arith_pkg::ST_CMP;
                    n_op = i_in_item.operation;
                    n_j = '0; n_cy = 1'b0; n_eq = 1'b1; n_dz = 1'b1;
                end
            end
            bcd_arith_pkg::ST_CMP: begin
                // lsd first subtract: final borrow gives a < b
                n_cy = s_sub_b;
                if (s_x != s_y) n_eq = 1'b0;
                if (s_y != 4'd0) n_dz = 1'b0;
                n_j = RIW'(r_j + 1'b1);
                if (s_last_j) begin
                    n_lt = s_sub_b;
                    n_j = '0; n_i = '0; n_cy = 1'b0; n_mcy = '0; n_qd = '0;
                    case (r_op)
                        bcd_arith_pkg::OP_ADD: n_state = bcd_arith_pkg::ST_ADD;
                        bcd_arith_pkg::OP_MUL: n_state = bcd_arith_pkg::ST_MUL;
                        bcd_arith_pkg::OP_DIV: begin
                            n_state = n_dz ? bcd_arith_pkg::ST_DONE
                                           : bcd_arith_pkg::ST_DIV;
                            n_i = IW'(DIGITS - 1);
                        end
                        default: n_state = bcd_arith_pkg::ST_DONE;
                    endcase
                end
            end
            bcd_arith_pkg::ST_ADD: begin
                n_cy = s_add_c;
                n_j = RIW'(r_j + 1'b1);
                if (s_last_j) n_state = bcd_arith_pkg::ST_DONE;
            end
            bcd_arith_pkg::ST_MUL: begin
                n_mcy = s_mac_c;
                n_j = RIW'(r_j + 1'b1);
                if (s_last_j) begin
                    n_j = '0; n_mcy = '0;
                    n_i = IW'(r_i + 1'b1);
                    if (32'(r_i) == 32'(DIGITS - 1)) n_state = bcd_arith_pkg::ST_DONE;
                end
            end
            bcd_arith_pkg::ST_DIV: begin
                // walk remainder digits lsd..msd subtracting divisor
                n_cy = s_sub_b;
                if (r_j == RIW'(RW - 1)) n_j = '0;
                else n_j = RIW'(r_j + 1'b1);
                if (r_j == RIW'(DIGITS)) begin
                    // one pass ends after the top digit
                    n_cy = 1'b0;
                    if (s_sub_b) begin
                        // trial failed: commit quotient digit, next position
                        n_qd = '0;
                        if (r_i == '0) n_state = bcd_arith_pkg::ST_DONE;
                        else n_i = IW'(r_i - 1'b1);
                    end else begin
                        n_qd = 4'(r_qd + 1'b1);
                    end
                end
            end
            bcd_arith_pkg::ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_state = bcd_arith_pkg::ST_IDLE;
                end
            end
            default: n_state = bcd_arith_pkg::ST_IDLE;
        endcase
    end

    // division: position i starts with rem = rem*10 + a[i], each trial sweeps
    // index j over digits 0..DIGITS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcd_arith_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op; r_i <= n_i; r_j <= n_j; r_cy <= n_cy; r_mcy <= n_mcy;
        r_lt <= n_lt; r_eq <= n_eq; r_dz <= n_dz; r_qd <= n_qd;
        case (r_state)
            bcd_arith_pkg::ST_IDLE: begin
                for (int k = 0; k < DIGITS; k++) begin
                    r_a[k] <= sat9(i_in_item.operand_a[4*k +: 4]);
                    r_b[k] <= sat9(i_in_item.operand_b[4*k +: 4]);
                    r_acc[k] <= '0;
                end
                for (int k = 0; k < RW; k++) r_rem[k] <= '0;
            end
            bcd_arith_pkg::ST_CMP: begin
                if (s_last_j && r_op == bcd_arith_pkg::OP_DIV) begin
                    // shift first dividend digit in
                    for (int k = RW - 1; k > 0; k--) r_rem[k] <= r_rem[k-1];
                    r_rem[0] <= r_a[DIGITS-1];
                end
            end
            bcd_arith_pkg::ST_ADD: r_acc[r_j[IW-1:0]] <= s_add_d;
            bcd_arith_pkg::ST_MUL: if (s_mul_in) r_acc[s_mul_k] <= s_mac_d;
            bcd_arith_pkg::ST_DIV: begin
                if (r_j != RIW'(DIGITS)) r_tmp[r_j] <= s_sub_d;
                else begin
                    if (s_sub_b) begin
                        r_acc[r_i] <= r_qd;
                        if (r_i != '0) begin
                            for (int k = RW - 1; k > 0; k--) r_rem[k] <= r_rem[k-1];
                            r_rem[0] <= r_a[IW'(r_i - 1'b1)];
                        end
                    end else begin
                        for (int k = 0; k < DIGITS; k++) r_rem[k] <= r_tmp[k];
                        r_rem[DIGITS] <= s_sub_d;
                    end
                end
            end
            default: ;
        endcase
        if (r_state == bcd_arith_pkg::ST_DONE && (!r_ovalid || !i_out_stall)) begin
            r_out.result_value <= s_res;
            r_out.less_than <= r_lt;
            r_out.equal <= r_eq;
            r_out.divide_by_zero <= (r_op == bcd_arith_pkg::OP_DIV) && r_dz;
        end
    end

    assign o_in_stall = (r_state != bcd_arith_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item = r_out;
endmodule
